>>> sv/tsgc_pkg.sv
// Package with types, constants and shared definitions of the time strip gap clusterer.
`timescale 1ns / 1ps
package tsgc_pkg;

  localparam int GroupDepth = 32;
  localparam int IdxW = $clog2(GroupDepth);
  localparam int FillW = $clog2(GroupDepth + 1);

  localparam logic [1:0] REG_MAX_TIME_GAP = 2'd0;
  localparam logic [1:0] REG_MAX_STRIP_GAP = 2'd1;
  localparam logic [1:0] REG_MIN_CLUSTER_SIZE = 2'd2;
  localparam logic [1:0] REG_INVALID = 2'd3;

  typedef struct packed {
    logic [31:0] hit_time;
    logic [15:0] hit_strip;
    logic        end_of_batch;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_time;
    logic [15:0] out_strip;
    logic [15:0] cluster_number;
    logic        cluster_end;
    logic        run_end;
    logic        group_overflow;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // One stored hit as held by a cell.
  typedef struct packed {
    logic        valid;
    logic [31:0] hit_time;
    logic [15:0] hit_strip;
  } hit_t;

  // Control broadcast to all cells of the sorted row.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_EMIT,
    ST_DROP,
    ST_DONE
  } state_t;

endpackage

>>> sv/tsgc_cell.sv
// One cell of the sorted hit row: holds a hit and takes part in a stable insertion or a left shift.
`timescale 1ns / 1ps
module tsgc_cell (
  input  logic                clk,
  input  logic                rst,
  input  tsgc_pkg::cell_ctrl_t ctrl,
  input  tsgc_pkg::hit_t      new_hit,
  input  tsgc_pkg::hit_t      left_hit,
  input  logic                left_moves,
  input  logic                left_full,
  input  tsgc_pkg::hit_t      right_hit,
  input  logic [16:0]         limit,
  output tsgc_pkg::hit_t      hit,
  output logic                moves,
  output logic                cut
);
  import tsgc_pkg::*;

  logic bigger;

  // A cell moves right when its hit sorts strictly after the new hit.
  assign bigger = hit.valid && (hit.hit_strip > new_hit.hit_strip);
  assign moves = bigger;
  // A cluster starts here when the strip step from the left neighbor is too large.
  assign cut = hit.valid && left_hit.valid
               && (({1'b0, hit.hit_strip} - {1'b0, left_hit.hit_strip}) > limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit.valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (left_moves) begin
        hit <= left_hit;
      end else if (bigger || (!hit.valid && left_full)) begin
        hit <= new_hit;
      end
    end else if (ctrl.shift) begin
      hit <= right_hit;
    end
  end

endmodule

>>> sv/tsgc_row.sv
// Row of cells that keeps the open group sorted by strip and shifts it out head first.
`timescale 1ns / 1ps
module tsgc_row (
  input  logic                         clk,
  input  logic                         rst,
  input  tsgc_pkg::cell_ctrl_t         ctrl,
  input  tsgc_pkg::hit_t               new_hit,
  input  logic [16:0]                  limit,
  output tsgc_pkg::hit_t               head,
  output logic [tsgc_pkg::GroupDepth-1:0] cuts
);
  import tsgc_pkg::*;

  hit_t cells [GroupDepth];
  logic mv [GroupDepth];
  hit_t empty_hit;

  assign empty_hit = '0;

  for (genvar g = 0; g < GroupDepth; g++) begin : g_cell
    hit_t lh, rh;
    logic lm, lf;
    if (g == 0) begin : g_first
      assign lh = empty_hit;
      assign lm = 1'b0;
      assign lf = 1'b1;
    end else begin : g_mid
      assign lh = cells[g-1];
      assign lm = mv[g-1];
      assign lf = cells[g-1].valid;
    end
    if (g == GroupDepth - 1) begin : g_last
      assign rh = empty_hit;
    end else begin : g_inner
      assign rh = cells[g+1];
    end
    tsgc_cell u_cell (
      .clk,
      .rst,
      .ctrl,
      .new_hit,
      .left_hit(lh),
      .left_moves(lm),
      .left_full(lf),
      .right_hit(rh),
      .limit,
      .hit(cells[g]),
      .moves(mv[g]),
      .cut(cuts[g])
    );
  end

  assign head = cells[0];

endmodule

>>> sv/time_strip_gap_clusterer_core.sv
// Top level of the time strip gap clusterer: control, segmenting and output register.
// A hit that closes no group is first accepted, then inserted in place in the row.
// When a group closes, each cluster is scanned one hit a cycle, then emitted or dropped
// one hit a cycle; emission pauses while the output stalls.
// Each result waits in a staging register until the next is known, so the last carries run_end.
// Synchronous reset empties the row, zeroes counters and loads register defaults.
`timescale 1ns / 1ps
module time_strip_gap_clusterer_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tsgc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tsgc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  tsgc_pkg::cfg_item_t  cfg_data
);
  import tsgc_pkg::*;

  state_t state, state_next;
  logic [31:0] max_time_gap;
  logic [15:0] max_strip_gap;
  logic [5:0]  min_cluster_size;
  logic [31:0] previous_time;
  logic [15:0] cluster_count;
  logic [FillW-1:0] fill;
  logic [FillW-1:0] fill_after;
  in_item_t    item;
  logic        close_ovf;
  logic        gap_pending;
  logic [FillW-1:0] seg_len;
  logic [FillW-1:0] scan_pos;
  out_item_t   stage;
  logic        stage_valid;
  cell_ctrl_t  ctrl;
  hit_t        new_hit, head;
  logic [GroupDepth-1:0] cuts;
  logic [16:0] limit;
  logic        take, out_free, gap_hit, stage_go, out_push;
  logic        seg_end, seg_keep, seg_last, seg_done;
  state_t      after_seg;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign take = in_valid && in_ready;
  assign gap_hit = (fill != '0) && ((in_data.hit_time - previous_time) > max_time_gap);
  assign limit = {1'b0, max_strip_gap} + 17'd1;
  assign new_hit = '{valid: 1'b1, hit_time: item.hit_time, hit_strip: item.hit_strip};
  assign seg_end = (scan_pos >= fill) || cuts[scan_pos[IdxW-1:0]];
  assign seg_keep = (seg_len >= min_cluster_size);
  assign seg_last = (seg_len == FillW'(1));
  assign stage_go = !stage_valid || out_free;
  assign fill_after = fill - 1'b1;
  assign seg_done = seg_last && ((state == ST_DROP) || (state == ST_EMIT && stage_go));
  assign after_seg = (fill_after != '0) ? ST_SCAN : (gap_pending ? ST_INSERT : ST_DONE);

  tsgc_row u_row (
    .clk, .rst, .ctrl, .new_hit, .limit, .head, .cuts
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (take) state_next = gap_hit ? ST_SCAN : ST_INSERT;
      ST_INSERT: begin
        if (fill == FillW'(GroupDepth - 1) || item.end_of_batch) state_next = ST_SCAN;
        else if (stage_valid) state_next = ST_DONE;
        else state_next = ST_IDLE;
      end
      ST_SCAN:   if (seg_end) state_next = seg_keep ? ST_EMIT : ST_DROP;
      ST_EMIT:   if (seg_done) state_next = after_seg;
      ST_DROP:   if (seg_done) state_next = after_seg;
      ST_DONE:   if (!stage_valid || out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    out_push = 1'b0;
    unique case (state)
      ST_INSERT: ctrl.insert = 1'b1;
      ST_EMIT: begin
        ctrl.shift = stage_go;
        out_push = stage_go && stage_valid;
      end
      ST_DROP:   ctrl.shift = 1'b1;
      ST_DONE:   out_push = stage_valid && out_free;
      default:   ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      max_time_gap <= 32'd200;
      max_strip_gap <= 16'd2;
      min_cluster_size <= 6'd3;
      previous_time <= '0;
      cluster_count <= '0;
      fill <= '0;
      out_valid <= 1'b0;
      gap_pending <= 1'b0;
      close_ovf <= 1'b0;
      seg_len <= '0;
      scan_pos <= '0;
      stage_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_data.index)
          REG_MAX_TIME_GAP:     max_time_gap <= cfg_data.data;
          REG_MAX_STRIP_GAP:    max_strip_gap <= cfg_data.data[15:0];
          REG_MIN_CLUSTER_SIZE: min_cluster_size <= cfg_data.data[5:0];
          default:              ;
        endcase
      end
      out_valid <= out_push || (out_valid && !out_ready);
      if (out_push) begin
        out_data <= '{out_time: stage.out_time, out_strip: stage.out_strip,
                      cluster_number: stage.cluster_number,
                      cluster_end: stage.cluster_end, run_end: (state == ST_DONE),
                      group_overflow: stage.group_overflow};
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            item <= in_data;
            previous_time <= in_data.hit_time;
            gap_pending <= gap_hit;
            close_ovf <= 1'b0;
            scan_pos <= FillW'(1);
            seg_len <= FillW'(1);
          end
        end
        ST_INSERT: begin
          fill <= fill + 1'b1;
          gap_pending <= 1'b0;
          close_ovf <= (fill == FillW'(GroupDepth - 1));
          scan_pos <= FillW'(1);
          seg_len <= FillW'(1);
        end
        ST_SCAN: begin
          if (!seg_end) begin
            scan_pos <= scan_pos + 1'b1;
            seg_len <= seg_len + 1'b1;
          end
        end
        ST_EMIT: begin
          if (stage_go) begin
            stage <= '{out_time: head.hit_time, out_strip: head.hit_strip,
                       cluster_number: cluster_count, cluster_end: seg_last,
                       run_end: 1'b0, group_overflow: close_ovf};
            stage_valid <= 1'b1;
            fill <= fill_after;
            if (seg_last) begin
              cluster_count <= cluster_count + 1'b1;
              scan_pos <= FillW'(1);
              seg_len <= FillW'(1);
            end else begin
              seg_len <= seg_len - 1'b1;
            end
          end
        end
        ST_DROP: begin
          fill <= fill_after;
          if (seg_last) begin
            scan_pos <= FillW'(1);
            seg_len <= FillW'(1);
          end else begin
            seg_len <= seg_len - 1'b1;
          end
        end
        ST_DONE: if (out_free) stage_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    fill <= FillW'(GroupDepth))
    else $error("fill above depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !stage_valid)
    else $error("staged result left behind at idle");

endmodule
